// File: rtl/core/fisher_exact_tail_pvalue_assert.svh
// Assertion macros shared by the checkers of the Fisher exact tail block.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef FISHER_EXACT_TAIL_PVALUE_ASSERT_SVH
`define FISHER_EXACT_TAIL_PVALUE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define FET_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define FET_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// File: rtl/core/fet_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and width functions of the Fisher exact tail block.
// No dependencies; every other module of the block but fet_ram imports this package.
package fet_pkg;

  localparam int TABLE_TOP_DEF = 1023;
  localparam int CELL_W        = 10;
  localparam int SUM_W         = 12;
  localparam int P_W           = 32;
  localparam int LF_FRAC       = 24;
  localparam int ROOT_N        = 24;
  localparam int ROOT_ITERS    = 32;
  localparam int L2_FRAC       = 28;
  localparam int MRG_READS     = 5;
  localparam int TERM_READS    = 4;
  localparam int Y_W           = 29;
  localparam int Z_W           = 30;

  localparam logic [31:0]    LN2_Q32     = 32'd2977044472;
  localparam logic [30:0]    INV_LN2_Q30 = 31'd1549082005;
  localparam logic [Y_W-1:0] EXP_CUT     = Y_W'(23 << LF_FRAC);

  // Address width of the log-factorial table.
  function automatic int idx_width(input int top);
    return $clog2(top + 1);
  endfunction

  // Entry width: ln(n!) <= n * ln(n) < n * 0.7 * ceil(log2(n + 1)).
  function automatic int lf_width(input int top);
    int lg;
    lg = idx_width(top);
    return $clog2((top * lg * 7) / 10 + 2) + LF_FRAC;
  endfunction

  typedef struct packed {
    logic              kind;
    logic [CELL_W-1:0] cell_a;
    logic [CELL_W-1:0] cell_b;
    logic [CELL_W-1:0] cell_c;
    logic [CELL_W-1:0] cell_d;
  } fet_in_t;

  typedef struct packed {
    logic [P_W-1:0] p_value;
    logic           too_large;
  } fet_out_t;

  typedef enum logic [4:0] {
    S_ROOT_LD, S_ROOT_IT, S_ROOT_ST, S_FILL_ZERO, S_FILL_LD, S_FILL_SQ,
    S_FILL_MUL, S_FILL_WR, S_IDLE, S_SEL, S_MRG, S_TRD, S_ZMUL, S_EXP,
    S_ACC, S_OUT
  } fet_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ROOT_LD, OP_ROOT_IT, OP_ROOT_ST, OP_FILL_ZERO, OP_FILL_LD,
    OP_FILL_SQ, OP_FILL_MUL, OP_FILL_WR, OP_TAKE, OP_MRG, OP_TRD, OP_ZMUL,
    OP_EXP, OP_ACC, OP_OUT
  } fet_op_t;

  typedef struct packed {
    fet_op_t    op;
    logic [4:0] step;
  } fet_cmd_t;

  typedef struct packed {
    logic root_last;
    logic fill_last;
    logic too_large;
    logic iter_last;
  } fet_sts_t;

endpackage

// File: rtl/core/fet_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: rtl/core/fet_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the Fisher exact tail block: table build after reset, then per-item steps.
// Depends on fet_pkg.
module fet_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fet_pkg::fet_sts_t sts,
  output fet_pkg::fet_cmd_t cmd
);
  import fet_pkg::*;

  fet_state_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ROOT_LD;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = OP_NONE;
    cmd.step      = step_r;
    in_stall      = 1'b1;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_ROOT_LD: begin
        cmd.op    = OP_ROOT_LD;
        step_nxt  = '0;
        state_nxt = S_ROOT_IT;
      end
      S_ROOT_IT: begin
        cmd.op   = OP_ROOT_IT;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(ROOT_ITERS - 1)) begin
          state_nxt = S_ROOT_ST;
        end
      end
      S_ROOT_ST: begin
        cmd.op    = OP_ROOT_ST;
        state_nxt = sts.root_last ? S_FILL_ZERO : S_ROOT_LD;
      end
      S_FILL_ZERO: begin
        cmd.op    = OP_FILL_ZERO;
        state_nxt = S_FILL_LD;
      end
      S_FILL_LD: begin
        cmd.op    = OP_FILL_LD;
        step_nxt  = '0;
        state_nxt = S_FILL_SQ;
      end
      S_FILL_SQ: begin
        cmd.op   = OP_FILL_SQ;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(L2_FRAC - 1)) begin
          state_nxt = S_FILL_MUL;
        end
      end
      S_FILL_MUL: begin
        cmd.op    = OP_FILL_MUL;
        state_nxt = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd.op    = OP_FILL_WR;
        state_nxt = sts.fill_last ? S_IDLE : S_FILL_LD;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_TAKE;
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        step_nxt  = '0;
        state_nxt = sts.too_large ? S_OUT : S_MRG;
      end
      S_MRG: begin
        cmd.op   = OP_MRG;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(MRG_READS)) begin
          step_nxt  = '0;
          state_nxt = S_TRD;
        end
      end
      S_TRD: begin
        cmd.op   = OP_TRD;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(TERM_READS)) begin
          state_nxt = S_ZMUL;
        end
      end
      S_ZMUL: begin
        cmd.op    = OP_ZMUL;
        step_nxt  = '0;
        state_nxt = S_EXP;
      end
      S_EXP: begin
        cmd.op   = OP_EXP;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(ROOT_N - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        step_nxt  = '0;
        state_nxt = sts.iter_last ? S_OUT : S_TRD;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_ROOT_LD;
      end
    endcase
  end

  assign out_valid = out_valid_r;
endmodule

// File: rtl/core/fet_dp.sv
`timescale 1ns / 1ps
// Datapath of the Fisher exact tail block: root chain, log-factorial builder, exp unit, sum.
// Depends on fet_pkg and fet_ram.
module fet_dp #(
  parameter int TABLE_TOP = fet_pkg::TABLE_TOP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fet_pkg::fet_in_t  in_data,
  input  fet_pkg::fet_cmd_t cmd,
  output fet_pkg::fet_sts_t sts,
  output fet_pkg::fet_out_t out_data
);
  import fet_pkg::*;

  localparam int IW = idx_width(TABLE_TOP);
  localparam int LW = lf_width(TABLE_TOP);
  localparam int BW = LW + 4;
  localparam int EW = $clog2(IW + 1);
  localparam int CW = CELL_W + 1;
  localparam int RW = $clog2(ROOT_N);

  // Root chain and square-root unit.
  logic [31:0]   root_r [ROOT_N];
  logic [RW-1:0] rk_r, rk_nxt;
  logic [63:0]   sv_r, sv_nxt, sr_r, sr_nxt, sb_r, sb_nxt;

  // Log-factorial builder.
  logic [IW-1:0]      fi_r, fi_nxt;
  logic [EW-1:0]      fe_r, fe_nxt;
  logic [IW:0]        fp_r, fp_nxt;
  logic [31:0]        x_r, x_nxt;
  logic [L2_FRAC-1:0] frac_r, frac_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [LW-1:0]      lacc_r, lacc_nxt;

  // Item state and exp unit.
  logic              kind_r, kind_nxt, tl_r, tl_nxt;
  logic [CW-1:0]     ca_r, cb_r, cc_r, cd_r, ca_nxt, cb_nxt, cc_nxt, cd_nxt;
  logic [CELL_W-1:0] lim_r, lim_nxt, iter_r, iter_nxt;
  logic [BW-1:0]     base_r, base_nxt, dn_r, dn_nxt;
  logic [Z_W-1:0]    z_r, z_nxt;
  logic              zero_r, zero_nxt;
  logic [32:0]       m_r, m_nxt, sum_r, sum_nxt;
  fet_out_t          out_r, out_nxt;

  // RAM port.
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [LW-1:0] ram_wdata, ram_rdata;

  // Combinational helpers.
  logic [63:0]        sq, sum_rb, prod_l2;
  logic [31:0]        l2;
  logic [64:0]        lnq_wide, mexp;
  logic [LW-1:0]      lf_new;
  logic [IW:0]        fi_inc;
  logic [SUM_W-1:0]   n_in, m_ab, m_cd, m_ac, m_bd, n_cur;
  logic [BW-1:0]      y_pos;
  logic [59:0]        zprod;
  logic [LF_FRAC-1:0] z_frac;
  logic [5:0]         q;
  logic [32:0]        term;
  logic [33:0]        sum_wide;
  logic [4:0]         fsh;

  fet_ram #(.WIDTH(LW), .DEPTH(TABLE_TOP + 1)) u_lf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign n_in  = SUM_W'(in_data.cell_a) + SUM_W'(in_data.cell_b)
               + SUM_W'(in_data.cell_c) + SUM_W'(in_data.cell_d);
  assign m_ab  = SUM_W'(ca_r) + SUM_W'(cb_r);
  assign m_cd  = SUM_W'(cc_r) + SUM_W'(cd_r);
  assign m_ac  = SUM_W'(ca_r) + SUM_W'(cc_r);
  assign m_bd  = SUM_W'(cb_r) + SUM_W'(cd_r);
  assign n_cur = m_ab + m_cd;

  assign sum_rb   = sr_r + sb_r;
  assign sq       = 64'(x_r) * 64'(x_r);
  assign l2       = (32'(fe_r) << L2_FRAC) | 32'(frac_r);
  assign prod_l2  = 64'(l2) * 64'(LN2_Q32);
  assign lnq_wide = (65'(prod_r) + (65'd1 << 35)) >> 36;
  assign lf_new   = lacc_r + LW'(lnq_wide);
  assign fi_inc   = (IW + 1)'(fi_r) + 1'b1;
  assign fsh      = 5'(31 - int'(fe_r));

  assign y_pos    = dn_r[BW-1] ? '0 : dn_r;
  assign zprod    = 60'(y_pos[Y_W-1:0]) * 60'(INV_LN2_Q30);
  assign z_frac   = z_r[LF_FRAC-1:0];
  assign mexp     = 65'(m_r) * 65'(root_r[cmd.step]);
  assign q        = z_r[Z_W-1:LF_FRAC];
  assign term     = (zero_r || (q > 6'd32)) ? '0 : (m_r >> q);
  assign sum_wide = 34'(sum_r) + 34'(term);

  always_comb begin
    rk_nxt   = rk_r;   sv_nxt   = sv_r;   sr_nxt   = sr_r;   sb_nxt = sb_r;
    fi_nxt   = fi_r;   fe_nxt   = fe_r;   fp_nxt   = fp_r;   x_nxt  = x_r;
    frac_nxt = frac_r; prod_nxt = prod_r; lacc_nxt = lacc_r;
    kind_nxt = kind_r; tl_nxt   = tl_r;
    ca_nxt   = ca_r;   cb_nxt   = cb_r;   cc_nxt   = cc_r;   cd_nxt = cd_r;
    lim_nxt  = lim_r;  iter_nxt = iter_r; base_nxt = base_r; dn_nxt = dn_r;
    z_nxt    = z_r;    zero_nxt = zero_r; m_nxt    = m_r;    sum_nxt = sum_r;
    out_nxt  = out_r;
    ram_we    = 1'b0;
    ram_waddr = fi_r;
    ram_wdata = lf_new;
    ram_raddr = '0;
    case (cmd.op)
      OP_ROOT_LD: begin
        sv_nxt = (rk_r == '0) ? (64'd1 << 63) : {sr_r[31:0], 32'd0};
        sr_nxt = '0;
        sb_nxt = 64'd1 << 62;
      end
      OP_ROOT_IT: begin
        if (sv_r >= sum_rb) begin
          sv_nxt = sv_r - sum_rb;
          sr_nxt = (sr_r >> 1) + sb_r;
        end else begin
          sr_nxt = sr_r >> 1;
        end
        sb_nxt = sb_r >> 2;
      end
      OP_ROOT_ST: begin
        rk_nxt = rk_r + 1'b1;
      end
      OP_FILL_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
        lacc_nxt  = '0;
        fi_nxt    = IW'(1);
        fe_nxt    = '0;
        fp_nxt    = (IW + 1)'(2);
      end
      OP_FILL_LD: begin
        x_nxt    = 32'(fi_r) << fsh;
        frac_nxt = '0;
      end
      OP_FILL_SQ: begin
        // Squaring pushes the mantissa past two exactly when the next log2 bit is one.
        if (sq[63]) begin
          frac_nxt = {frac_r[L2_FRAC-2:0], 1'b1};
          x_nxt    = sq[63:32];
        end else begin
          frac_nxt = {frac_r[L2_FRAC-2:0], 1'b0};
          x_nxt    = sq[62:31];
        end
      end
      OP_FILL_MUL: begin
        prod_nxt = prod_l2;
      end
      OP_FILL_WR: begin
        ram_we   = 1'b1;
        lacc_nxt = lf_new;
        fi_nxt   = fi_inc[IW-1:0];
        if (fi_inc == fp_r) begin
          fe_nxt = fe_r + 1'b1;
          fp_nxt = fp_r << 1;
        end
      end
      OP_TAKE: begin
        kind_nxt = in_data.kind;
        ca_nxt   = CW'(in_data.cell_a);
        cb_nxt   = CW'(in_data.cell_b);
        cc_nxt   = CW'(in_data.cell_c);
        cd_nxt   = CW'(in_data.cell_d);
        if (in_data.kind) begin
          lim_nxt = (in_data.cell_b < in_data.cell_c) ? in_data.cell_b : in_data.cell_c;
        end else begin
          lim_nxt = (in_data.cell_a < in_data.cell_d) ? in_data.cell_a : in_data.cell_d;
        end
        iter_nxt = '0;
        sum_nxt  = '0;
        base_nxt = '0;
        tl_nxt   = 32'(n_in) > 32'(TABLE_TOP);
      end
      OP_MRG: begin
        // Margin terms are fixed for the item: base = L(n) minus the four margin entries.
        case (cmd.step)
          5'd0: ram_raddr = IW'(m_ab);
          5'd1: ram_raddr = IW'(m_cd);
          5'd2: ram_raddr = IW'(m_ac);
          5'd3: ram_raddr = IW'(m_bd);
          5'd4: ram_raddr = IW'(n_cur);
          default: ram_raddr = '0;
        endcase
        if (cmd.step == 5'(MRG_READS)) begin
          base_nxt = base_r + BW'(ram_rdata);
        end else if (cmd.step != 5'd0) begin
          base_nxt = base_r - BW'(ram_rdata);
        end
      end
      OP_TRD: begin
        case (cmd.step)
          5'd0: ram_raddr = IW'(ca_r);
          5'd1: ram_raddr = IW'(cb_r);
          5'd2: ram_raddr = IW'(cc_r);
          5'd3: ram_raddr = IW'(cd_r);
          default: ram_raddr = '0;
        endcase
        dn_nxt = (cmd.step == 5'd0) ? base_r : dn_r + BW'(ram_rdata);
      end
      OP_ZMUL: begin
        zero_nxt = y_pos >= BW'(EXP_CUT);
        z_nxt    = zprod[59:30];
        m_nxt    = 33'd1 << 32;
      end
      OP_EXP: begin
        if (z_frac[5'(ROOT_N - 1) - cmd.step]) begin
          m_nxt = mexp[64:32];
        end
      end
      OP_ACC: begin
        if (!sum_r[32]) begin
          sum_nxt = (sum_wide[33] || sum_wide[32]) ? (33'd1 << 32) : sum_wide[32:0];
        end
        iter_nxt = iter_r + 1'b1;
        if (kind_r) begin
          ca_nxt = ca_r + 1'b1; cb_nxt = cb_r - 1'b1;
          cc_nxt = cc_r - 1'b1; cd_nxt = cd_r + 1'b1;
        end else begin
          ca_nxt = ca_r - 1'b1; cb_nxt = cb_r + 1'b1;
          cc_nxt = cc_r + 1'b1; cd_nxt = cd_r - 1'b1;
        end
      end
      OP_OUT: begin
        out_nxt.p_value   = sum_r[32] ? '1 : sum_r[31:0];
        out_nxt.too_large = tl_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_r <= '0;
    end else begin
      rk_r <= rk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ROOT_ST) begin
      root_r[rk_r] <= sr_r[31:0];
    end
    sv_r   <= sv_nxt;   sr_r   <= sr_nxt;   sb_r   <= sb_nxt;
    fi_r   <= fi_nxt;   fe_r   <= fe_nxt;   fp_r   <= fp_nxt;   x_r  <= x_nxt;
    frac_r <= frac_nxt; prod_r <= prod_nxt; lacc_r <= lacc_nxt;
    kind_r <= kind_nxt; tl_r   <= tl_nxt;
    ca_r   <= ca_nxt;   cb_r   <= cb_nxt;   cc_r   <= cc_nxt;   cd_r <= cd_nxt;
    lim_r  <= lim_nxt;  iter_r <= iter_nxt; base_r <= base_nxt; dn_r <= dn_nxt;
    z_r    <= z_nxt;    zero_r <= zero_nxt; m_r    <= m_nxt;    sum_r <= sum_nxt;
    out_r  <= out_nxt;
  end

  assign sts.root_last = (rk_r == RW'(ROOT_N - 1));
  assign sts.fill_last = (32'(fi_r) == 32'(TABLE_TOP));
  assign sts.too_large = tl_r;
  assign sts.iter_last = (iter_r == lim_r);
  assign out_data      = out_r;
endmodule

// File: rtl/core/fisher_exact_tail_pvalue.sv
`timescale 1ns / 1ps
// Top level of the one-tailed Fisher exact test block: sequencer, datapath and table RAM.
// Depends on fet_pkg, fet_ctrl, fet_dp and fet_ram.
//
// Usage: one 2x2 table (cell_a..cell_d) and a tail select enter per transfer on the in_
// channel; one result (p_value, too_large) leaves per transfer on the out_ channel.
// After rst_n is released the block builds its tables before it takes any item: the
// 24-entry square-root chain and then the ln(i!) table, one entry for each i up to
// TABLE_TOP. in_stall stays high until this is done.
// An item with total n > TABLE_TOP gives too_large and p_value zero. Otherwise the result
// is the sum of T tail terms, where T is min(cell_a, cell_d) + 1 for the left tail and
// min(cell_b, cell_c) + 1 for the right tail: each summed term takes four reads of the
// table RAM and 24 steps of the serial exp unit, which applies one root-chain multiply
// for each set fraction bit.
// The next transfer can be taken once the result is loaded into the output register.
// One item is in work at a time. The result sits in an output register; when out_stall
// holds it there, the block still takes and works on the next item and waits only to
// hand that one over.
module fisher_exact_tail_pvalue #(
  parameter int TABLE_TOP = fet_pkg::TABLE_TOP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fet_pkg::fet_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fet_pkg::fet_out_t out_data
);
  import fet_pkg::*;

  fet_cmd_t cmd;
  fet_sts_t sts;

  // The sequencer owns the handshakes and the step counter.
  fet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the table RAM, the exp unit and the result register.
  fet_dp #(.TABLE_TOP(TABLE_TOP)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );
endmodule

// File: rtl/core/fet_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the Fisher exact tail block and its bind to the top level.
// Depends on fet_pkg and fisher_exact_tail_pvalue_assert.svh.
`include "fisher_exact_tail_pvalue_assert.svh"

module fet_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input fet_pkg::fet_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input fet_pkg::fet_out_t out_data
);
  import fet_pkg::*;

  // A stalled result holds its place and value.
  `FET_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  // An oversized table always reports a zero p-value.
  `FET_ASSERT_SAME(a_too_large_zero, clk, rst_n, out_valid && out_data.too_large, out_data.p_value == '0, "too_large with nonzero p_value")
  // Only one item is in work: a transfer in closes the input side.
  `FET_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall, "input open right after a transfer")
  // A new result only follows a busy cycle.
  `FET_ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(out_valid), $past(in_stall), "result without work")
endmodule

bind fisher_exact_tail_pvalue fet_checker u_fet_checker (.*);

// File: bench/tb_fisher_exact_tail_pvalue.sv
`timescale 1ns / 1ps
// Self-checking testbench of the one-tailed Fisher exact p-value block.
// Depends on fet_pkg and fisher_exact_tail_pvalue; a scoreboard class predicts every result.
module tb_fisher_exact_tail_pvalue;
  import fet_pkg::*;

  localparam int TOP         = TABLE_TOP_DEF;
  localparam int N_RANDOM    = 1130;
  localparam longint LIMIT   = 3000000;
  localparam int DRAIN_WAIT  = 40;

  // Scoreboard: holds the fixed-point ln(i!) table and the root chain, predicts the
  // tail sum of each accepted table and compares results in order.
  class pvalue_board;
    longint unsigned lnfact[TOP+1];
    longint unsigned roots[ROOT_N];
    fet_out_t        pending[$];
    int              errors;
    int              checked;

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= r + bitv) begin
          v -= r + bitv;
          r = (r >> 1) + bitv;
        end else begin
          r >>= 1;
        end
        bitv >>= 2;
      end
      return r;
    endfunction

    // Natural log of k with 24 fraction bits, from a bitwise log2.
    function longint unsigned ln_fixed(int unsigned k);
      int unsigned e;
      longint unsigned x, l2;
      e = 0;
      while (e < 31 && (k >> (e + 1)) != 0) e++;
      x = longint'(k) << (31 - e);
      l2 = longint'(e) << L2_FRAC;
      for (int j = L2_FRAC - 1; j >= 0; j--) begin
        x = (x * x) >> 31;
        if (x >= (64'd1 << 32)) begin
          l2 |= 64'd1 << j;
          x >>= 1;
        end
      end
      return (l2 * 64'(LN2_Q32) + (64'd1 << 35)) >> 36;
    endfunction

    function void build();
      roots[0] = isqrt(64'd1 << 63);
      for (int k = 1; k < ROOT_N; k++) roots[k] = isqrt(roots[k-1] << 32);
      lnfact[0] = 0;
      for (int i = 1; i <= TOP; i++) lnfact[i] = lnfact[i-1] + ln_fixed(i);
      errors = 0;
      checked = 0;
    endfunction

    // exp(-y) with 32 fraction bits, y with 24 fraction bits.
    function longint unsigned exp_neg(longint unsigned y);
      longint unsigned z, q, m;
      if (y >= (64'd23 << LF_FRAC)) return 0;
      z = (y * 64'(INV_LN2_Q30)) >> 30;
      q = z >> LF_FRAC;
      m = 64'd1 << 32;
      for (int k = 0; k < ROOT_N; k++)
        if ((z >> (23 - k)) & 64'd1) m = (m * roots[k]) >> 32;
      if (q > 32) return 0;
      return m >> q;
    endfunction

    function longint unsigned hyper_term(int a, int b, int c, int d);
      longint unsigned up, dn;
      up = lnfact[a+b] + lnfact[c+d] + lnfact[a+c] + lnfact[b+d];
      dn = lnfact[a] + lnfact[b] + lnfact[c] + lnfact[d] + lnfact[a+b+c+d];
      return exp_neg(dn > up ? dn - up : 0);
    endfunction

    function void note_input(fet_in_t x);
      int a, b, c, d, lim;
      longint unsigned acc;
      fet_out_t res;
      a = x.cell_a; b = x.cell_b; c = x.cell_c; d = x.cell_d;
      acc = 0;
      if (a + b + c + d > TOP) begin
        res.p_value = '0;
        res.too_large = 1'b1;
      end else begin
        if (x.kind == 1'b0) begin
          lim = a < d ? a : d;
          for (int i = 0; i <= lim; i++) acc += hyper_term(a-i, b+i, c+i, d-i);
        end else begin
          lim = b < c ? b : c;
          for (int i = 0; i <= lim; i++) acc += hyper_term(a+i, b-i, c-i, d+i);
        end
        res.p_value = (acc > 64'hFFFFFFFF) ? 32'hFFFFFFFF : acc[31:0];
        res.too_large = 1'b0;
      end
      pending.push_back(res);
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH: %s", what);
    endtask

    task check_result(fet_out_t got);
      fet_out_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result p=%h tl=%b", got.p_value, got.too_large));
      end else begin
        want = pending.pop_front();
        if (got.p_value !== want.p_value)
          report($sformatf("p_value %h, expected %h", got.p_value, want.p_value));
        if (got.too_large !== want.too_large)
          report($sformatf("too_large %b, expected %b", got.too_large, want.too_large));
      end
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  fet_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  fet_out_t out_data;

  pvalue_board board;
  int          send_idle_pct;
  int          recv_stall_pct;
  longint      cycles;

  fisher_exact_tail_pvalue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // The watchdog bounds the run, which includes the startup table build.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver checks each result transfer and picks a fresh stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // One input transfer: optional idle cycles, then hold the item until it is taken.
  task send_table(fet_in_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (in_stall);
    board.note_input(x);
  endtask

  function fet_in_t make_table(bit kind, int a, int b, int c, int d);
    fet_in_t x;
    x.kind = kind;
    x.cell_a = a[CELL_W-1:0];
    x.cell_b = b[CELL_W-1:0];
    x.cell_c = c[CELL_W-1:0];
    x.cell_d = d[CELL_W-1:0];
    return x;
  endfunction

  // Mostly valid tables with a short tail walk; some oversized totals and a few long walks.
  function fet_in_t random_table();
    int pick, s0, s1, w0, w1;
    bit kind;
    pick = $urandom_range(99);
    kind = $urandom_range(1);
    if (pick < 8) begin
      return make_table(kind, $urandom_range(1023), $urandom_range(1023),
                        $urandom_range(1023), $urandom_range(1023));
    end
    if (pick < 10) begin
      s0 = $urandom_range(250, 100);
      s1 = $urandom_range(250, 100);
      w0 = $urandom_range(200);
      w1 = $urandom_range(200);
    end else begin
      s0 = $urandom_range(15);
      s1 = $urandom_range(300);
      w0 = $urandom_range(300);
      w1 = $urandom_range(300);
      if ($urandom_range(1)) begin
        {s0, s1} = {s1, s0};
      end
    end
    // The walking pair is a/d on the left tail and b/c on the right tail.
    if (kind == 1'b0) return make_table(kind, s0, w0, w1, s1);
    return make_table(kind, w0, s0, s1, w1);
  endfunction

  initial begin
    fet_in_t dir[$];
    board = new();
    board.build();
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed tables: the empty table saturates, single full cells hit the top, totals
    // just over the top are flagged, and long walks drive terms into underflow.
    for (int k = 0; k < 2; k++) begin
      dir.push_back(make_table(k, 0, 0, 0, 0));
      dir.push_back(make_table(k, 1023, 0, 0, 0));
      dir.push_back(make_table(k, 0, 1023, 0, 0));
      dir.push_back(make_table(k, 0, 0, 1023, 0));
      dir.push_back(make_table(k, 0, 0, 0, 1023));
      dir.push_back(make_table(k, 1023, 1023, 1023, 1023));
      dir.push_back(make_table(k, 1023, 1, 0, 0));
      dir.push_back(make_table(k, 256, 256, 256, 256));
      dir.push_back(make_table(k, 3, 1, 1, 3));
      dir.push_back(make_table(k, 1, 5, 5, 1));
    end
    dir.push_back(make_table(0, 511, 0, 0, 511));
    dir.push_back(make_table(1, 0, 511, 511, 0));
    dir.push_back(make_table(0, 255, 256, 256, 255));
    dir.push_back(make_table(1, 10, 500, 500, 10));
    foreach (dir[i]) send_table(dir[i]);

    // Four pressure phases over the random stimulus.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int i = 0; i < N_RANDOM / 4; i++) send_table(random_table());
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.pending.size() != 0) board.report("results still outstanding at the end");

    $display("Covered %0d result transfers over directed tables and four idle/stall phases.",
             board.checked);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
